// ----- design/ctbs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the cumulative-table bin search block.
// Used by ctbs_ctrl, ctbs_dp and the top level; depends on nothing.
package ctbs_pkg;

  // Field widths
  localparam int unsigned IDX_W       = 8;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned BIN_W       = 8;
  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 8;

  // Default table depth
  localparam int unsigned TABLE_DEPTH_DEF = 256;

  // Request kinds carried in in_tuser
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  // Source of the table read addresses
  typedef enum logic [1:0] {
    ADDR_FIRST,   // port A reads entry 1
    ADDR_CUR,     // ports read mid-1 and mid from the registered midpoint
    ADDR_NEXT     // ports read mid-1 and mid from the next midpoint
  } addr_sel_t;

  // Kind of result captured at the end of a search
  typedef enum logic [1:0] {
    RES_ONE,
    RES_MID,
    RES_MISS
  } res_kind_t;

  typedef struct packed {
    logic      start;
    logic      write;
    logic      step;
    addr_sel_t addr_sel;
    logic      res_load;
    res_kind_t res_kind;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic first_hit;
    logic iter_hit;
    logic empty_cur;
    logic empty_nxt;
  } dp_sts_t;

endpackage

// ----- design/cumulative_table_bin_search_top.sv -----
`timescale 1ns / 1ps
// Top level of the cumulative-table bin search block.
// Depends on ctbs_pkg, ctbs_ctrl, ctbs_dp and ctbs_ram.
//
//   channel   direction  carries
//   in_*      input      load (index, value) or search (probe, bin count)
//   out_*     output     one result per search: bin number, not-found flag
//
// A load is written to the table and the block stays ready for the next item.
// A search checks the first bin and then takes from 1 to 8 binary search
// steps; a hit on the first bin or a zero bin count ends it at the check.
// No new item is accepted until the search result is registered. Each step
// is paced by the two-port table read feeding the
// compare. Synchronous active-low reset clears the controller and the output
// valid; the table keeps its contents. A result that waits on out_tready
// holds the next search in its final state, while a new item is still
// accepted as long as only one result is waiting.
module cumulative_table_bin_search_top #(
  parameter int unsigned TABLE_DEPTH = ctbs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [7:0] entry_index, [39:8] entry_value, [71:40] probe, [79:72] used_entries
  input  logic [ctbs_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] req_type
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] bin_number
  output logic [ctbs_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] not_found
  output logic                                out_tuser
);

  ctbs_pkg::dp_cmd_t cmd;
  ctbs_pkg::dp_sts_t sts;

  ctbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .req_type   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ctbs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .sts          (sts),
    .entry_index  (in_tdata[7:0]),
    .entry_value  (in_tdata[39:8]),
    .probe        (in_tdata[71:40]),
    .used_entries (in_tdata[79:72]),
    .bin_number   (out_tdata),
    .not_found    (out_tuser)
  );

endmodule

// ----- design/ctbs_ram.sv -----
`timescale 1ns / 1ps
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module ctbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read both ports every cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ----- design/ctbs_dp.sv -----
`timescale 1ns / 1ps
// Datapath: table memory, search bounds, comparisons and result registers.
// Depends on ctbs_pkg and ctbs_ram.
module ctbs_dp #(
  parameter int unsigned TABLE_DEPTH = ctbs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  ctbs_pkg::dp_cmd_t             cmd,
  output ctbs_pkg::dp_sts_t             sts,
  input  logic [ctbs_pkg::IDX_W-1:0]    entry_index,
  input  logic [ctbs_pkg::VAL_W-1:0]    entry_value,
  input  logic [ctbs_pkg::VAL_W-1:0]    probe,
  input  logic [ctbs_pkg::IDX_W-1:0]    used_entries,
  output logic [ctbs_pkg::BIN_W-1:0]    bin_number,
  output logic                          not_found
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned PW = (AW > ctbs_pkg::IDX_W) ? AW : ctbs_pkg::IDX_W;
  localparam logic [16:0] DEPTH_V = 17'(TABLE_DEPTH);

  logic [ctbs_pkg::VAL_W-1:0] probe_r;
  logic [8:0]                 lo_r, hi_r;
  logic [7:0]                 mid_r;
  logic [ctbs_pkg::BIN_W-1:0] res_bin_r, out_bin_r;
  logic                       res_miss_r, out_miss_r;
  logic                       oob_a_r, oob_b_r;

  logic [8:0]  sum_st, mid_plus, mid_minus, lo_nxt, hi_nxt;
  logic [9:0]  sum_nxt;
  logic [7:0]  mid_nxt, pos_a, pos_b;
  logic [PW-1:0] pos_a_ext, pos_b_ext, idx_ext;
  logic        wr_en;
  logic [ctbs_pkg::VAL_W-1:0] rd_a, rd_b, va, vb;
  logic        go_up;

  // Next bounds of one search step
  always_comb begin
    mid_plus  = {1'b0, mid_r} + 9'd1;
    mid_minus = {1'b0, mid_r} - 9'd1;
    go_up     = probe_r > vb;
    lo_nxt    = go_up ? mid_plus : lo_r;
    hi_nxt    = go_up ? hi_r : mid_minus;
    sum_nxt   = {1'b0, lo_nxt} + {1'b0, hi_nxt};
    mid_nxt   = sum_nxt[8:1];
    sum_st    = 9'd1 + {1'b0, used_entries};
  end

  // Read addresses
  always_comb begin
    case (cmd.addr_sel)
      ctbs_pkg::ADDR_NEXT: pos_b = mid_nxt;
      default:             pos_b = mid_r;
    endcase
    if (cmd.addr_sel == ctbs_pkg::ADDR_FIRST) begin
      pos_a = 8'd1;
    end else begin
      pos_a = pos_b - 8'd1;
    end
    pos_a_ext = PW'(pos_a);
    pos_b_ext = PW'(pos_b);
    idx_ext   = PW'(entry_index);
    wr_en     = cmd.write && ({9'd0, entry_index} < DEPTH_V);
  end

  ctbs_ram #(
    .WIDTH (ctbs_pkg::VAL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (idx_ext[AW-1:0]),
    .wr_data   (entry_value),
    .rd_addr_a (pos_a_ext[AW-1:0]),
    .rd_data_a (rd_a),
    .rd_addr_b (pos_b_ext[AW-1:0]),
    .rd_data_b (rd_b)
  );

  // Positions past the table read as zero
  assign va = oob_a_r ? '0 : rd_a;
  assign vb = oob_b_r ? '0 : rd_b;

  // Status back to the controller
  always_comb begin
    sts.first_hit = probe_r <= va;
    sts.iter_hit  = (probe_r > va) && (probe_r <= vb);
    sts.empty_cur = lo_r > hi_r;
    sts.empty_nxt = lo_nxt > hi_nxt;
  end

  // Search registers and results
  always_ff @(posedge clk) begin
    oob_a_r <= {9'd0, pos_a} >= DEPTH_V;
    oob_b_r <= {9'd0, pos_b} >= DEPTH_V;
    if (cmd.start) begin
      probe_r <= probe;
      lo_r    <= 9'd1;
      hi_r    <= {1'b0, used_entries};
      mid_r   <= sum_st[8:1];
    end else if (cmd.step) begin
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      mid_r <= mid_nxt;
    end
    if (cmd.res_load) begin
      case (cmd.res_kind)
        ctbs_pkg::RES_ONE: begin
          res_bin_r  <= 8'd1;
          res_miss_r <= 1'b0;
        end
        ctbs_pkg::RES_MID: begin
          res_bin_r  <= mid_r;
          res_miss_r <= 1'b0;
        end
        default: begin
          res_bin_r  <= '0;
          res_miss_r <= 1'b1;
        end
      endcase
    end
    if (cmd.out_load) begin
      out_bin_r  <= res_bin_r;
      out_miss_r <= res_miss_r;
    end
  end

  assign bin_number = out_bin_r;
  assign not_found  = out_miss_r;

endmodule

// ----- design/ctbs_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: sequences the first-bin check and the binary search steps,
// and owns the handshakes. Depends on ctbs_pkg.
module ctbs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              req_type,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  ctbs_pkg::dp_sts_t sts,
  output ctbs_pkg::dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_acc, slot_free;

  assign in_acc    = in_tvalid && (state_r == ST_IDLE);
  assign slot_free = !out_valid_r || out_tready;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.addr_sel  = ctbs_pkg::ADDR_FIRST;
    cmd.res_kind  = ctbs_pkg::RES_MISS;
    case (state_r)
      ST_IDLE: begin
        cmd.write = in_acc && (req_type == ctbs_pkg::REQ_LOAD);
        if (in_acc && (req_type == ctbs_pkg::REQ_SEARCH)) begin
          cmd.start = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.addr_sel = ctbs_pkg::ADDR_CUR;
        if (sts.first_hit) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = ctbs_pkg::RES_ONE;
          state_nxt    = ST_FINISH;
        end else if (sts.empty_cur) begin
          cmd.res_load = 1'b1;
          state_nxt    = ST_FINISH;
        end else begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.addr_sel = ctbs_pkg::ADDR_NEXT;
        if (sts.iter_hit) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = ctbs_pkg::RES_MID;
          state_nxt    = ST_FINISH;
        end else if (sts.empty_nxt) begin
          cmd.res_load = 1'b1;
          state_nxt    = ST_FINISH;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

// ----- tb/tb_cumulative_table_bin_search_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for cumulative_table_bin_search_top: loads table entries,
// runs bin searches and checks each answer against a software bin lookup.
// Depends on ctbs_pkg and the cumulative_table_bin_search_top RTL.

// Expected answer of one search
typedef struct packed {
  logic [7:0] bin;
  logic       miss;
} bin_answer_t;

// Shadow of the cumulative table plus the queue of answers still owed by the block
class bin_lookup_checker;
  logic [31:0] cdf_shadow [256];
  bin_answer_t pending_answers [$];
  int          mismatches = 0;

  // Locate the bin holding probe with the same first-bin check and halving steps
  function automatic bin_answer_t locate_bin(logic [31:0] probe, logic [7:0] bin_cnt);
    int lo;
    int hi;
    int mid;
    bin_answer_t ans;
    ans.bin  = 8'd1;
    ans.miss = 1'b0;
    if (probe <= cdf_shadow[1]) return ans;
    lo = 1;
    hi = int'(bin_cnt);
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (probe > cdf_shadow[mid-1] && probe <= cdf_shadow[mid]) begin
        ans.bin = mid[7:0];
        return ans;
      end
      if (probe > cdf_shadow[mid]) lo = mid + 1;
      else hi = mid - 1;
    end
    ans.bin  = 8'd0;
    ans.miss = 1'b1;
    return ans;
  endfunction

  // Record one accepted input transaction
  function void note_request(logic req, logic [ctbs_pkg::IN_TDATA_W-1:0] data);
    if (req == ctbs_pkg::REQ_LOAD) begin
      cdf_shadow[data[7:0]] = data[39:8];
    end else begin
      pending_answers.insert(pending_answers.size(), locate_bin(data[71:40], data[79:72]));
    end
  endfunction

  // Compare one accepted result transaction with the oldest pending answer
  function void check_answer(logic [7:0] bin, logic miss);
    bin_answer_t want;
    bit          bad;
    bad = 1'b0;
    if (pending_answers.size() == 0) begin
      bad = 1'b1;
      want = '0;
    end else begin
      want = pending_answers.pop_front();
      bad = (want.bin !== bin) || (want.miss !== miss);
    end
    if (bad) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: result bin=%0d not_found=%0b, expected %s bin=%0d not_found=%0b",
                 $time, bin, miss, (pending_answers.size() == 0 && want == '0) ?
                 "(maybe none)" : "", want.bin, want.miss);
      end
    end
  endfunction
endclass

module tb_cumulative_table_bin_search_top;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int ITEM_TARGET  = 650;
  localparam int DRAIN_CYCLES = 20;

  // Table shapes used when refilling
  localparam int SHAPE_CDF   = 0;  // monotone from 0.0 up to 1.0
  localparam int SHAPE_FLAT  = 1;  // monotone with many repeated entries
  localparam int SHAPE_NOISE = 2;  // arbitrary, non-monotone
  localparam int SHAPE_WIDE  = 3;  // monotone, reaching past 1.0 to all ones

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [ctbs_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic        in_tuser   = ctbs_pkg::REQ_LOAD;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [ctbs_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic        out_tuser;

  int          cycle_cnt      = 0;
  int          items_sent     = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;

  // Stimulus-side copy of the table, used to pick legal bin counts and probes
  logic [31:0] gen_tbl     [256];
  bit          gen_written [256];

  bin_lookup_checker sb = new();

  always #5 clk = ~clk;

  cumulative_table_bin_search_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Randomly stall the result channel
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Observe both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_request(in_tuser, in_tdata);
      if (out_tvalid && out_tready) sb.check_answer(out_tdata, out_tuser);
    end
  end

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Present one transaction after a random gap and hold it until accepted
  task automatic send_item(logic req, logic [7:0] idx, logic [31:0] val,
                           logic [31:0] probe, logic [7:0] bin_cnt);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {bin_cnt, probe, val, idx};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic load_entry(int idx, logic [31:0] val);
    gen_tbl[idx]     = val;
    gen_written[idx] = 1'b1;
    send_item(ctbs_pkg::REQ_LOAD, idx[7:0], val, $urandom, 8'($urandom_range(0, 255)));
  endtask

  task automatic search(logic [31:0] probe, int bin_cnt);
    send_item(ctbs_pkg::REQ_SEARCH, 8'($urandom_range(0, 255)), $urandom, probe,
              bin_cnt[7:0]);
  endtask

  // Number of consecutively loaded entries from index 0
  function automatic int loaded_prefix();
    int cnt;
    cnt = 0;
    while (cnt < 256 && gen_written[cnt]) cnt++;
    return cnt;
  endfunction

  // Rewrite entries 0..depth-1 following a shape
  task automatic fill_table(int depth, int shape);
    logic [63:0] acc;
    logic [63:0] ceiling;
    logic [31:0] step_max;
    ceiling  = (shape == SHAPE_WIDE) ? 64'hFFFF_FFFF : 64'h8000_0000;
    step_max = 32'(ceiling * 2 / depth);
    acc      = (shape == SHAPE_WIDE) ? 64'($urandom_range(0, step_max)) : 64'd0;
    for (int i = 0; i < depth; i++) begin
      if (shape == SHAPE_NOISE) begin
        acc = 64'($urandom);
      end else if (i == depth - 1 && $urandom_range(0, 3) != 0) begin
        acc = ceiling;
      end else if (i > 0 && !(shape == SHAPE_FLAT && $urandom_range(0, 1) == 1)) begin
        acc = acc + 64'($urandom_range(0, step_max));
        if (acc > ceiling) acc = ceiling;
      end
      load_entry(i, acc[31:0]);
    end
  endtask

  // One search over loaded entries only, with the probe often on a boundary
  task automatic random_search();
    int          top;
    int          bin_cnt;
    int          k;
    logic [31:0] probe;
    top     = loaded_prefix() - 1;
    bin_cnt = ($urandom_range(0, 7) == 0) ? top : $urandom_range(0, top);
    k       = $urandom_range(0, (bin_cnt > 1) ? bin_cnt : 1);
    case ($urandom_range(0, 7))
      0:       probe = 32'h0;
      1:       probe = gen_tbl[k];
      2:       probe = gen_tbl[k] + 32'd1;
      3:       probe = gen_tbl[k] - 32'd1;
      4:       probe = $urandom;
      5:       probe = 32'h8000_0000;
      6:       probe = 32'hFFFF_FFFF;
      default: probe = $urandom_range(0, 32'h8000_0000);
    endcase
    search(probe, bin_cnt);
  endtask

  // Hold the sender off until every outstanding answer has been returned
  task automatic drain_answers();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_answers.size() != 0) @(posedge clk);
  endtask

  initial begin
    int depth;
    int round;
    int count;
    for (int i = 0; i < 256; i++) gen_written[i] = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: small CDF with a repeated entry and an exact 1.0 top
    load_entry(0, 32'h0000_0000);
    load_entry(1, 32'h1000_0000);
    load_entry(2, 32'h2000_0000);
    load_entry(3, 32'h2000_0000);
    load_entry(4, 32'h6000_0000);
    load_entry(5, 32'h8000_0000);
    search(32'h0000_0000, 5);   // zero probe, first bin
    search(32'h1000_0000, 5);   // exactly on the first bin edge
    search(32'h1000_0001, 5);   // just past the first bin
    search(32'h2000_0000, 5);   // on a repeated boundary
    search(32'h7FFF_FFFF, 5);
    search(32'h8000_0000, 5);   // exactly 1.0
    search(32'h8000_0001, 5);   // above the top entry: miss
    search(32'hFFFF_FFFF, 5);
    search(32'h1000_0001, 0);   // zero bins and first-bin check fails
    search(32'h0000_0005, 0);   // zero bins but first-bin hit
    load_entry(255, 32'hFFFF_FFFF);
    load_entry(6, 32'h3000_0000);  // break monotonicity
    search(32'h7000_0000, 6);
    search(32'h2800_0000, 6);
    load_entry(7, 32'hFFFF_FFFF);  // entry beyond 1.0
    search(32'hFFFF_FFFF, 7);
    search(32'h9000_0000, 7);

    // Random rounds: refill part of the table, then search it
    round = 0;
    while (items_sent < ITEM_TARGET) begin
      drain_answers();
      case (round % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      depth = (round == 2) ? 256 : $urandom_range(3, 24);
      fill_table(depth, $urandom_range(SHAPE_CDF, SHAPE_WIDE));
      count = (depth == 256) ? 60 : $urandom_range(15, 30);
      for (int j = 0; j < count; j++) begin
        if ($urandom_range(0, 9) == 0) load_entry($urandom_range(0, 255), $urandom);
        else random_search();
      end
      round++;
    end

    // Wait for the last answers, then let the pipeline settle
    in_tvalid <= 1'b0;
    while (sb.pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_answers.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
